// ===== design/ckfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfc_pkg
// Shared constants and types for the coordinate keyed FIFO cache.
// ----------------------------------------------------------------------------
package ckfc_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int PAY_W    = 32;

  localparam logic [1:0] MODE_FIND  = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              key_we;
    logic              pay_we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  key_wdata;
    logic [PAY_W-1:0]  pay_wdata;
  } mem_req_t;

endpackage

// ===== design/coordinate_keyed_fifo_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_keyed_fifo_cache
// Cache of payload handles keyed by a signed (x,z) pair, FIFO replacement.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  in      | in_valid_i/in_ready_o, mode, key_x/z, payload | into block
//  out     | out_valid_o/out_ready_i, hit, found, evicted  | out of block
//
// A find walks the live slots newest first, one slot a cycle through the key
// and payload memories, and stops at the first match. An add only reads and
// writes its slot before the ring wraps; after, it also walks the other slots
// for duplicates of the evicted key. Liveness is the fill count, so reset and
// clear need no pass. A result waits in the output register; a stalled output
// holds the sequencer in its final state.
module coordinate_keyed_fifo_cache (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] key_x_i,
  input  logic signed [31:0] key_z_i,
  input  logic [31:0]        payload_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [31:0]        found_payload_o,
  output logic               evicted_o,
  output logic [31:0]        evicted_payload_o
);

  ckfc_pkg::mem_req_t                mem;
  logic [ckfc_pkg::KEY_W-1:0]        key_rdata;
  logic [ckfc_pkg::PAY_W-1:0]        pay_rdata;

  // sequencer: one request a cycle into both memories
  ckfc_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .key_i             ({$unsigned(key_x_i), $unsigned(key_z_i)}),
    .payload_i         (payload_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hit_o             (hit_o),
    .found_payload_o   (found_payload_o),
    .evicted_o         (evicted_o),
    .evicted_payload_o (evicted_payload_o),
    .mem_o             (mem),
    .key_rdata_i       (key_rdata),
    .pay_rdata_i       (pay_rdata)
  );

  // slot keys, {x, z}
  ckfc_ram #(
    .WIDTH (ckfc_pkg::KEY_W),
    .DEPTH (ckfc_pkg::CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem.key_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.key_wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (key_rdata)
  );

  // slot payloads, rewritten during the duplicate shift
  ckfc_ram #(
    .WIDTH (ckfc_pkg::PAY_W),
    .DEPTH (ckfc_pkg::CAPACITY)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (mem.pay_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.pay_wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (pay_rdata)
  );

endmodule

// ===== design/ckfc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfc_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ckfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/ckfc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfc_ctrl
// Sequencer: walks the slot ring through the memories, holds result register.
// ----------------------------------------------------------------------------
module ckfc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [ckfc_pkg::KEY_W-1:0]  key_i,
  input  logic [ckfc_pkg::PAY_W-1:0]  payload_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [ckfc_pkg::PAY_W-1:0]  found_payload_o,
  output logic                        evicted_o,
  output logic [ckfc_pkg::PAY_W-1:0]  evicted_payload_o,
  output ckfc_pkg::mem_req_t          mem_o,
  input  logic [ckfc_pkg::KEY_W-1:0]  key_rdata_i,
  input  logic [ckfc_pkg::PAY_W-1:0]  pay_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_S, ST_LD_S, ST_SCAN, ST_FIX, ST_WR, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic                         is_add_q, is_add_d;
  logic [ckfc_pkg::KEY_W-1:0]   key_q, key_d;
  logic [ckfc_pkg::PAY_W-1:0]   pay_q, pay_d;
  logic [ckfc_pkg::KEY_W-1:0]   okey_q, okey_d;
  logic [ckfc_pkg::PAY_W-1:0]   spay_q, spay_d;
  logic [ckfc_pkg::ADDR_W-1:0]  next_q, next_d;
  logic                         full_q, full_d;
  logic [ckfc_pkg::ADDR_W-1:0]  addr_q, addr_d;
  logic [ckfc_pkg::ADDR_W-1:0]  ridx_q, ridx_d;
  logic                         rv_q, rv_d;
  logic [ckfc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         havep_q, havep_d;
  logic [ckfc_pkg::ADDR_W-1:0]  prev_q, prev_d;
  logic                         rhit_q, rhit_d;
  logic [ckfc_pkg::PAY_W-1:0]   rfound_q, rfound_d;
  logic                         revict_q, revict_d;
  logic [ckfc_pkg::PAY_W-1:0]   rgone_q, rgone_d;
  logic                         ov_q, ov_d;
  logic                         oh_q, oh_d;
  logic [ckfc_pkg::PAY_W-1:0]   of_q, of_d;
  logic                         oe_q, oe_d;
  logic [ckfc_pkg::PAY_W-1:0]   oep_q, oep_d;
  logic                         match;

  function automatic logic [ckfc_pkg::ADDR_W-1:0] dec_wrap(
    input logic [ckfc_pkg::ADDR_W-1:0] a
  );
    if (a == '0) begin
      return ckfc_pkg::ADDR_W'(ckfc_pkg::CAPACITY - 1);
    end
    return a - 1'b1;
  endfunction

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = ov_q;
  assign hit_o             = oh_q;
  assign found_payload_o   = of_q;
  assign evicted_o         = oe_q;
  assign evicted_payload_o = oep_q;

  assign match = rv_q && (key_rdata_i == (is_add_q ? okey_q : key_q));

  always_comb begin
    state_d  = state_q;
    is_add_d = is_add_q;
    key_d    = key_q;
    pay_d    = pay_q;
    okey_d   = okey_q;
    spay_d   = spay_q;
    next_d   = next_q;
    full_d   = full_q;
    addr_d   = addr_q;
    ridx_d   = ridx_q;
    rv_d     = 1'b0;
    cnt_d    = cnt_q;
    havep_d  = havep_q;
    prev_d   = prev_q;
    rhit_d   = rhit_q;
    rfound_d = rfound_q;
    revict_d = revict_q;
    rgone_d  = rgone_q;
    ov_d     = ov_q && !out_ready_i;
    oh_d     = oh_q;
    of_d     = of_q;
    oe_d     = oe_q;
    oep_d    = oep_q;
    mem_o    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d    = key_i;
          pay_d    = payload_i;
          rhit_d   = 1'b0;
          rfound_d = '0;
          revict_d = 1'b0;
          rgone_d  = '0;
          is_add_d = 1'b0;
          case (mode_i)
            ckfc_pkg::MODE_FIND: begin
              addr_d  = dec_wrap(next_q);
              cnt_d   = full_q ? ckfc_pkg::CNT_W'(ckfc_pkg::CAPACITY)
                               : ckfc_pkg::CNT_W'(next_q);
              state_d = ST_SCAN;
            end
            ckfc_pkg::MODE_ADD: begin
              is_add_d = 1'b1;
              state_d  = ST_RD_S;
            end
            ckfc_pkg::MODE_CLEAR: begin
              next_d  = '0;
              full_d  = 1'b0;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RD_S: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = next_q;
        state_d     = ST_LD_S;
      end
      ST_LD_S: begin
        okey_d  = key_rdata_i;
        spay_d  = pay_rdata_i;
        rgone_d = pay_rdata_i;
        havep_d = 1'b0;
        if (full_q) begin
          addr_d  = dec_wrap(next_q);
          cnt_d   = ckfc_pkg::CNT_W'(ckfc_pkg::CAPACITY - 1);
          state_d = ST_SCAN;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_SCAN: begin
        // keep one read in flight, compare the one that returned
        if (cnt_q != '0) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = addr_q;
          ridx_d      = addr_q;
          rv_d        = 1'b1;
          addr_d      = dec_wrap(addr_q);
          cnt_d       = cnt_q - 1'b1;
        end
        if (match && !is_add_q) begin
          rhit_d   = 1'b1;
          rfound_d = pay_rdata_i;
          rv_d     = 1'b0;
          state_d  = ST_DONE;
        end else begin
          if (match) begin
            if (!havep_q) begin
              rgone_d = pay_rdata_i;
            end else begin
              // shift payload one place toward the newer end
              mem_o.pay_we    = 1'b1;
              mem_o.waddr     = prev_q;
              mem_o.pay_wdata = pay_rdata_i;
            end
            havep_d = 1'b1;
            prev_d  = ridx_q;
          end
          if (!rv_q && cnt_q == '0) begin
            state_d = is_add_q ? ST_FIX : ST_DONE;
          end
        end
      end
      ST_FIX: begin
        if (havep_q) begin
          mem_o.pay_we    = 1'b1;
          mem_o.waddr     = prev_q;
          mem_o.pay_wdata = spay_q;
        end
        revict_d = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        mem_o.key_we    = 1'b1;
        mem_o.pay_we    = 1'b1;
        mem_o.waddr     = next_q;
        mem_o.key_wdata = key_q;
        mem_o.pay_wdata = pay_q;
        if (next_q == ckfc_pkg::ADDR_W'(ckfc_pkg::CAPACITY - 1)) begin
          next_d = '0;
          full_d = 1'b1;
        end else begin
          next_d = next_q + 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oh_d    = rhit_q;
          of_d    = rfound_q;
          oe_d    = revict_q;
          oep_d   = revict_q ? rgone_q : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      next_q  <= '0;
      full_q  <= 1'b0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      full_q  <= full_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_add_q <= is_add_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    okey_q   <= okey_d;
    spay_q   <= spay_d;
    addr_q   <= addr_d;
    ridx_q   <= ridx_d;
    cnt_q    <= cnt_d;
    havep_q  <= havep_d;
    prev_q   <= prev_d;
    rhit_q   <= rhit_d;
    rfound_q <= rfound_d;
    revict_q <= revict_d;
    rgone_q  <= rgone_d;
    oh_q     <= oh_d;
    of_q     <= of_d;
    oe_q     <= oe_d;
    oep_q    <= oep_d;
  end

endmodule

// ===== design/ckfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckfc_checker
// Port level checks for the coordinate keyed FIFO cache.
// ----------------------------------------------------------------------------
module ckfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [31:0] found_payload_o,
  input logic        evicted_o,
  input logic [31:0] evicted_payload_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_payload_o)
      && $stable(evicted_payload_o))
    else $error("output transaction changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_payload_o == '0)
    else $error("found payload nonzero on miss");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_payload_o == '0)
    else $error("evicted payload nonzero without eviction");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction in one result");

endmodule

bind coordinate_keyed_fifo_cache ckfc_checker u_ckfc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .hit_o             (hit_o),
  .found_payload_o   (found_payload_o),
  .evicted_o         (evicted_o),
  .evicted_payload_o (evicted_payload_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for coordinate_keyed_fifo_cache: a directed table of
// finds, adds, clears and the unused mode, then random traffic on a small key
// pool so that duplicates and shared low key bits are common. Every result is
// compared with the table's expected result or an in-bench model of the ring.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int POOL_SIZE = 20;

  typedef struct {
    logic        hit;
    logic [31:0] found;
    logic        evicted;
    logic [31:0] evicted_pay;
  } cache_result_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] kx;
    logic [31:0] kz;
    logic [31:0] pay;
    bit          typed;
    cache_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = ckfc_pkg::MODE_FIND;
  logic signed [31:0] key_x_i = '0;
  logic signed [31:0] key_z_i = '0;
  logic [31:0] payload_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [31:0] found_payload_o;
  logic evicted_o;
  logic [31:0] evicted_payload_o;

  always #2 clk_i = ~clk_i;

  coordinate_keyed_fifo_cache i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .key_x_i, .key_z_i,
    .payload_i, .out_valid_o, .out_ready_i, .hit_o, .found_payload_o,
    .evicted_o, .evicted_payload_o
  );

  // Shadow copy of the slot ring.
  logic [31:0] ring_kx [ckfc_pkg::CAPACITY];
  logic [31:0] ring_kz [ckfc_pkg::CAPACITY];
  logic [31:0] ring_pay [ckfc_pkg::CAPACITY];
  bit ring_live [ckfc_pkg::CAPACITY];
  int unsigned ring_ptr = 0;
  bit ring_wrapped = 1'b0;

  cache_result_t pending_results[$];
  stim_row_t dir_rows[$];
  logic [31:0] pool_x [POOL_SIZE];
  logic [31:0] pool_z [POOL_SIZE];
  int errors = 0;
  bit in_fire, out_fire;
  int idle_cycles = 0;

  // Apply one transaction to the shadow ring and return the result it causes.
  function automatic cache_result_t cache_apply(logic [1:0] mode, logic [31:0] kx,
                                                logic [31:0] kz, logic [31:0] pay);
    cache_result_t r;
    int unsigned idx, prev, s;
    logic [31:0] ox, oz;
    bit have_prev;
    r = '{1'b0, 32'd0, 1'b0, 32'd0};
    if (mode == ckfc_pkg::MODE_FIND) begin
      for (int k = 1; k <= ckfc_pkg::CAPACITY; k++) begin
        idx = (ring_ptr + ckfc_pkg::CAPACITY - k) % ckfc_pkg::CAPACITY;
        if (ring_live[idx] && ring_kx[idx] == kx && ring_kz[idx] == kz) begin
          r.hit = 1'b1;
          r.found = ring_pay[idx];
          break;
        end
      end
    end else if (mode == ckfc_pkg::MODE_ADD) begin
      s = ring_ptr;
      if (ring_wrapped && ring_live[s]) begin
        // Evict the newest duplicate; shift older payloads toward the newer end.
        ox = ring_kx[s];
        oz = ring_kz[s];
        r.evicted_pay = ring_pay[s];
        have_prev = 1'b0;
        prev = 0;
        for (int k = 1; k < ckfc_pkg::CAPACITY; k++) begin
          idx = (ring_ptr + ckfc_pkg::CAPACITY - k) % ckfc_pkg::CAPACITY;
          if (ring_live[idx] && ring_kx[idx] == ox && ring_kz[idx] == oz) begin
            if (!have_prev) r.evicted_pay = ring_pay[idx];
            else ring_pay[prev] = ring_pay[idx];
            prev = idx;
            have_prev = 1'b1;
          end
        end
        if (have_prev) ring_pay[prev] = ring_pay[s];
        r.evicted = 1'b1;
      end
      ring_kx[s] = kx;
      ring_kz[s] = kz;
      ring_pay[s] = pay;
      ring_live[s] = 1'b1;
      s++;
      if (s >= ckfc_pkg::CAPACITY) begin
        s = 0;
        ring_wrapped = 1'b1;
      end
      ring_ptr = s;
    end else if (mode == ckfc_pkg::MODE_CLEAR) begin
      foreach (ring_live[i]) ring_live[i] = 1'b0;
      ring_ptr = 0;
      ring_wrapped = 1'b0;
    end
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Drive one transaction and hold it until accepted, then predict it.
  task automatic send_item(stim_row_t row);
    int gap;
    bit taken;
    cache_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= row.mode;
    key_x_i <= row.kx;
    key_z_i <= row.kz;
    payload_i <= row.pay;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    r = cache_apply(row.mode, row.kx, row.kz, row.pay);
    pending_results.push_back(row.typed ? row.res : r);
  endtask

  function automatic stim_row_t make_row(logic [1:0] mode, logic [31:0] kx,
                                         logic [31:0] kz, logic [31:0] pay);
    stim_row_t row;
    row.mode = mode;
    row.kx = kx;
    row.kz = kz;
    row.pay = pay;
    row.typed = 1'b0;
    row.res = '{1'b0, 32'd0, 1'b0, 32'd0};
    return row;
  endfunction

  task automatic add_row(logic [1:0] mode, logic [31:0] kx, logic [31:0] kz,
                         logic [31:0] pay, bit typed, cache_result_t res);
    stim_row_t row;
    row = make_row(mode, kx, kz, pay);
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // Random item from the key pool, occasionally a fully random key.
  function automatic stim_row_t random_row(int add_pct, int clear_pct);
    int r, p;
    logic [1:0] mode;
    logic [31:0] kx, kz;
    r = $urandom_range(0, 99);
    if (r < add_pct) mode = ckfc_pkg::MODE_ADD;
    else if (r < add_pct + clear_pct) mode = ckfc_pkg::MODE_CLEAR;
    else if (r < add_pct + clear_pct + 2) mode = MODE_UNUSED;
    else mode = ckfc_pkg::MODE_FIND;
    p = $urandom_range(0, POOL_SIZE - 1);
    kx = pool_x[p];
    kz = pool_z[p];
    if ($urandom_range(0, 9) == 0) begin
      kx = $urandom;
      kz = $urandom;
    end
    return make_row(mode, kx, kz, $urandom);
  endfunction

  // Sample both handshakes mid-cycle; the values hold until the next edge.
  always @(negedge clk_i) begin
    cache_result_t want;
    in_fire = in_valid_i && in_ready_o;
    out_fire = out_valid_o && out_ready_i;
    if (rst_ni && out_fire) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result hit=%b found=%h evicted=%b evicted_payload=%h",
                 $time, hit_o, found_payload_o, evicted_o, evicted_payload_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, hit_o);
          errors++;
        end
        if (found_payload_o !== want.found) begin
          $display("%0t: found_payload expected %h actual %h",
                   $time, want.found, found_payload_o);
          errors++;
        end
        if (evicted_o !== want.evicted) begin
          $display("%0t: evicted expected %b actual %b", $time, want.evicted, evicted_o);
          errors++;
        end
        if (evicted_payload_o !== want.evicted_pay) begin
          $display("%0t: evicted_payload expected %h actual %h",
                   $time, want.evicted_pay, evicted_payload_o);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: random stalls, with calm stretches where ready stays high.
  initial begin
    int stall, calm;
    stall = 0;
    calm = 0;
    forever begin
      @(posedge clk_i);
      if (calm > 0) begin
        calm--;
        out_ready_i <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 199) == 0) calm = $urandom_range(100, 2000);
        else stall = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("coordinate_keyed_fifo_cache test failed");
      $finish;
    end
  end

  initial begin
    cache_result_t none, hit_ff, hit_0, hit_1;
    none = '{1'b0, 32'd0, 1'b0, 32'd0};
    hit_ff = '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0};
    hit_0 = '{1'b1, 32'd0, 1'b0, 32'd0};
    hit_1 = '{1'b1, 32'd1, 1'b0, 32'd0};
    foreach (ring_live[i]) ring_live[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      // Few low-bit patterns, so several keys share their low six bits.
      pool_x[i] = {26'($urandom_range(0, 32'h3FF_FFFF)), 6'($urandom_range(0, 2))};
      pool_z[i] = {26'($urandom_range(0, 32'h3FF_FFFF)), 6'($urandom_range(0, 2))};
      if (i % 2) begin
        pool_x[i][31:6] = ~pool_x[i][31:6];
        pool_z[i][31:6] = ~pool_z[i][31:6];
      end
    end

    // Directed table: extremes, duplicates, keys one bit apart, clear, unused mode.
    add_row(ckfc_pkg::MODE_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1, none);
    add_row(ckfc_pkg::MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1, hit_ff);
    add_row(ckfc_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, hit_0);
    add_row(ckfc_pkg::MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1, hit_1);
    add_row(ckfc_pkg::MODE_FIND, 32'h8000_0040, 32'h7FFF_FFFF, 32'd0, 1, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h8000_0000, 32'h7FFF_FFBF, 32'd0, 1, none);
    add_row(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1, hit_0);
    add_row(ckfc_pkg::MODE_CLEAR, 32'd0, 32'd0, 32'd0, 1, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1, none);
    add_row(ckfc_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 0, none);
    add_row(ckfc_pkg::MODE_ADD, 32'h0000_003F, 32'h0000_003F, 32'hAAAA_AAAA, 0, none);
    add_row(ckfc_pkg::MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0, none);
    add_row(ckfc_pkg::MODE_FIND, 32'h0000_003F, 32'h0000_003F, 32'd0, 0, none);
    add_row(ckfc_pkg::MODE_ADD, 32'd0, 32'd0, 32'h1234_5678, 0, none);
    add_row(ckfc_pkg::MODE_FIND, 32'd0, 32'd0, 32'd0, 0, none);
    add_row(ckfc_pkg::MODE_FIND, 32'd1, 32'd0, 32'd0, 0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random traffic with occasional clears.
    for (int i = 0; i < 700; i++) send_item(random_row(45, 3));

    // Start over and build up many duplicates with add-heavy traffic.
    send_item(make_row(ckfc_pkg::MODE_CLEAR, 32'd0, 32'd0, 32'd0));
    for (int i = 0; i < 480; i++) send_item(random_row(75, 0));
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("coordinate_keyed_fifo_cache test passed");
    else $display("coordinate_keyed_fifo_cache test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ckfc_pkg.sv
design/ckfc_ram.sv
design/ckfc_ctrl.sv
design/coordinate_keyed_fifo_cache.sv
design/ckfc_checker.sv
tb/testbench.sv
